// ===== rtl/midi_running_status_reassembler_unit_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros for the running status reassembler
// ----------------------------------------------------------------------------
`ifndef MIDI_RUNNING_STATUS_REASSEMBLER_UNIT_MACROS_SVH
`define MIDI_RUNNING_STATUS_REASSEMBLER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define MRSR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked out of reset
`define MRSR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MRSR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define MRSR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/mrsr_pkg.sv =====
// ----------------------------------------------------------------------------
// mrsr_pkg
// shared types and constants of the running status reassembler
// ----------------------------------------------------------------------------
package mrsr_pkg;

  // message queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // status byte codes and class bounds
  localparam logic [7:0] ST_NONE      = 8'h00;
  localparam logic [7:0] ST_PROG_LOW  = 8'hC0;
  localparam logic [7:0] ST_BEND_LOW  = 8'hE0;
  localparam logic [7:0] ST_SYS_LOW   = 8'hF0;
  localparam logic [7:0] ST_MTC_QF    = 8'hF1;
  localparam logic [7:0] ST_SONG_POS  = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
  localparam logic [7:0] ST_TUNE_REQ  = 8'hF6;
  localparam logic [4:0] RT_PREFIX    = 5'b11111;

  // message lengths
  localparam logic [1:0] LEN_NONE  = 2'd0;
  localparam logic [1:0] LEN_ONE   = 2'd1;
  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  // one whole message, bytes sent in order b0, b1, b2
  typedef struct packed {
    logic [1:0] len;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } msg_t;

endpackage

// ===== rtl/mrsr_front.sv =====
// ----------------------------------------------------------------------------
// mrsr_front
// takes received bytes, tracks running status and builds whole messages
// ----------------------------------------------------------------------------
module mrsr_front import mrsr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output logic       msg_push,
  output msg_t       msg
);

  logic [7:0] last_status_r, last_status_nxt;
  logic [7:0] running_r, running_nxt;
  logic       pending_r, pending_nxt;
  logic [6:0] first_data_r, first_data_nxt;
  logic       is_status, is_rt, held_class;

  assign is_status  = rx_byte[7];
  assign is_rt      = (rx_byte[7:3] == RT_PREFIX);
  // note on/off, poly aftertouch, control change, pitch bend keep a first data byte
  assign held_class = (running_r < ST_PROG_LOW) ||
                      ((running_r >= ST_BEND_LOW) && (running_r < ST_SYS_LOW));

  // classify the beat and work out the next state
  always_comb begin
    last_status_nxt = last_status_r;
    running_nxt     = running_r;
    pending_nxt     = pending_r;
    first_data_nxt  = first_data_r;
    msg.len = LEN_NONE;
    msg.b0  = rx_byte;
    msg.b1  = rx_byte;
    msg.b2  = rx_byte;
    priority if (is_rt) begin
      msg.len = LEN_ONE;
    end else if (is_status) begin
      last_status_nxt = rx_byte;
      running_nxt     = rx_byte;
      pending_nxt     = 1'b0;
      if (rx_byte == ST_TUNE_REQ) msg.len = LEN_ONE;
    end else if (pending_r) begin
      pending_nxt = 1'b0;
      msg.len = LEN_THREE;
      msg.b0  = last_status_r;
      msg.b1  = {1'b0, first_data_r};
    end else if (running_r == ST_NONE) begin
      msg.len = LEN_NONE;
    end else if (held_class) begin
      pending_nxt    = 1'b1;
      first_data_nxt = rx_byte[6:0];
    end else if (running_r < ST_BEND_LOW) begin
      msg.len = LEN_TWO;
      msg.b0  = last_status_r;
    end else begin
      // system common clears running status
      running_nxt = ST_NONE;
      if (running_r == ST_SONG_POS) begin
        pending_nxt    = 1'b1;
        first_data_nxt = rx_byte[6:0];
      end else if ((running_r == ST_MTC_QF) || (running_r == ST_SONG_SEL)) begin
        msg.len = LEN_TWO;
        msg.b0  = last_status_r;
      end
    end
  end

  assign msg_push = accept && (msg.len != LEN_NONE);

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_status_r <= ST_NONE;
      running_r     <= ST_NONE;
      pending_r     <= 1'b0;
      first_data_r  <= 7'd0;
    end else if (accept) begin
      last_status_r <= last_status_nxt;
      running_r     <= running_nxt;
      pending_r     <= pending_nxt;
      first_data_r  <= first_data_nxt;
    end
  end

endmodule

// ===== rtl/mrsr_queue.sv =====
// ----------------------------------------------------------------------------
// mrsr_queue
// short message queue between the front and the back
// ----------------------------------------------------------------------------
module mrsr_queue import mrsr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  msg_t wr_msg,
  output logic q_full,
  input  logic rd_en,
  output msg_t rd_msg,
  output logic q_empty
);

  msg_t              slots_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_wr, do_rd;

  assign q_full  = (count_r == QCNT_W'(QDEPTH));
  assign q_empty = (count_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_msg  = slots_r[rd_ptr_r];

  // slot storage
  always_ff @(posedge clk) begin
    if (do_wr) slots_r[wr_ptr_r] <= wr_msg;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (do_rd) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (do_wr && !do_rd) count_r <= count_r + QCNT_W'(1);
      else if (do_rd && !do_wr) count_r <= count_r - QCNT_W'(1);
    end
  end

endmodule

// ===== rtl/mrsr_back.sv =====
// ----------------------------------------------------------------------------
// mrsr_back
// sends each queued message one byte per beat, marking its last byte
// ----------------------------------------------------------------------------
`include "midi_running_status_reassembler_unit_macros.svh"
module mrsr_back import mrsr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  msg_t       q_msg,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] tx_byte,
  output logic       last_of_run
);

  msg_t       cur_r;
  logic [1:0] idx_r, idx_nxt;
  logic       busy_r, busy_nxt;
  logic       take, load;

  assign empty       = !busy_r;
  assign take        = pop && busy_r;
  assign last_of_run = (idx_r == (cur_r.len - 2'd1));
  assign load        = (!busy_r || (take && last_of_run)) && !q_empty;
  assign q_pop       = load;

  // byte select
  always_comb begin
    unique case (idx_r)
      2'd0:    tx_byte = cur_r.b0;
      2'd1:    tx_byte = cur_r.b1;
      default: tx_byte = cur_r.b2;
    endcase
  end

  // next index and busy flag
  always_comb begin
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    priority if (load) begin
      idx_nxt  = 2'd0;
      busy_nxt = 1'b1;
    end else if (take && last_of_run) begin
      busy_nxt = 1'b0;
    end else if (take) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  // current message
  always_ff @(posedge clk) begin
    if (load) cur_r <= q_msg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= 2'd0;
      busy_r <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      busy_r <= busy_nxt;
    end
  end

  // checks
  `MRSR_ASSERT_IMP(a_len_valid, clk, rst_n, busy_r, (cur_r.len != LEN_NONE) && (idx_r < cur_r.len), "byte index beyond message length")
  `MRSR_ASSERT_NXT(a_mid_stays, clk, rst_n, take && !last_of_run, busy_r && (idx_r == $past(idx_r) + 2'd1), "message cut short")
  `MRSR_ASSERT_IMP(a_load_src, clk, rst_n, q_pop, !q_empty && (!busy_r || (pop && last_of_run)), "load without a finished message")

endmodule

// ===== rtl/midi_running_status_reassembler_unit.sv =====
// path: a byte that completes a message is written to the queue, then loaded into the
//   sender's current-message register; a message of n bytes gives n result beats
// throughput: one input byte per cycle while full is low, one result byte per cycle
//   while pop is high; a four-message queue between parser and sender absorbs bursts
// reset: synchronous, active low; clears running status, pending flag and queue
// ----------------------------------------------------------------------------
// midi_running_status_reassembler_unit
// rebuilds whole messages from a received byte stream under running status
// ----------------------------------------------------------------------------
module midi_running_status_reassembler_unit import mrsr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_rx_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_tx_byte,
  output logic       out_last_of_run
);

  logic accept, msg_push, q_full, q_empty, q_pop;
  msg_t msg, q_msg;

  assign full   = q_full;
  assign accept = push && !q_full;

  // parser
  mrsr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .rx_byte  (in_rx_byte),
    .msg_push (msg_push),
    .msg      (msg)
  );

  // message queue
  mrsr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (msg_push),
    .wr_msg  (msg),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_msg  (q_msg),
    .q_empty (q_empty)
  );

  // byte sender
  mrsr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_msg       (q_msg),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .tx_byte     (out_tx_byte),
    .last_of_run (out_last_of_run)
  );

endmodule

// ===== verif/tb_midi_running_status_reassembler_unit.sv =====
// ----------------------------------------------------------------------------
// tb_midi_running_status_reassembler_unit
// self-checking bench: directed MIDI byte table, then random phrases (running
// status runs, system common, real-time interleave, cut-off messages, noise)
// checked beat by beat against a behavioural reassembler, with bursty input
// and a patterned, once long, result stall
// ----------------------------------------------------------------------------
module tb_midi_running_status_reassembler_unit import mrsr_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 260;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 20;

  // one result beat
  typedef struct packed {
    logic [7:0] tx;
    logic       last;
  } beat_t;

  // directed row; typed rows carry n expected bytes, b0 in the top byte
  typedef struct packed {
    logic [7:0]  rx;
    logic        typed;
    logic [1:0]  n;
    logic [23:0] bytes;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_tx_byte;
  logic       out_last_of_run;

  // predictor state
  logic [7:0] rs_last;
  logic [7:0] rs_running;
  logic       rs_pending;
  logic [6:0] rs_first;

  beat_t      step_beats[$];
  beat_t      due_beats[$];
  logic       byte_ignored;
  int         n_fail = 0;
  int         cycles = 0;
  int         burst_left = 1;
  int         hold_req = 0;

  dir_row_t   dir_rows [25];

  midi_running_status_reassembler_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_rx_byte      (in_rx_byte),
    .empty           (empty),
    .pop             (pop),
    .out_tx_byte     (out_tx_byte),
    .out_last_of_run (out_last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("midi_running_status_reassembler_unit verification failed");
      $finish;
    end
  end

  function automatic void add_beat(input logic [7:0] b, input logic last);
    step_beats.push_back('{tx: b, last: last});
  endfunction

  // behavioural reassembler: one received byte in, its result beats out
  task automatic reassemble_byte(input logic [7:0] b);
    logic [7:0] rs;
    rs = rs_running;
    step_beats.delete();
    byte_ignored = 1'b0;
    if (b[7]) begin
      if (b[7:3] == RT_PREFIX) begin
        add_beat(b, 1'b1);
      end else begin
        // new status drops any half-built message
        rs_last    = b;
        rs_running = b;
        rs_pending = 1'b0;
        if (b == ST_TUNE_REQ) add_beat(b, 1'b1);
      end
    end else if (rs_pending) begin
      rs_pending = 1'b0;
      add_beat(rs_last, 1'b0);
      add_beat({1'b0, rs_first}, 1'b0);
      add_beat(b, 1'b1);
    end else if (rs == ST_NONE) begin
      byte_ignored = 1'b1;
    end else if (rs < ST_PROG_LOW || (rs >= ST_BEND_LOW && rs < ST_SYS_LOW)) begin
      rs_pending = 1'b1;
      rs_first   = b[6:0];
    end else if (rs < ST_BEND_LOW) begin
      add_beat(rs_last, 1'b0);
      add_beat(b, 1'b1);
    end else begin
      // system common never runs on
      rs_running = ST_NONE;
      if (rs == ST_SONG_POS) begin
        rs_pending = 1'b1;
        rs_first   = b[6:0];
      end else if (rs == ST_MTC_QF || rs == ST_SONG_SEL) begin
        add_beat(rs_last, 1'b0);
        add_beat(b, 1'b1);
      end else begin
        byte_ignored = 1'b1;
      end
    end
  endtask

  // offer one byte, wait for the beat, then maybe open a gap
  task automatic send_byte(input logic [7:0] b);
    int gap;
    push       <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    reassemble_byte(b);
    foreach (step_beats[i]) due_beats.push_back(step_beats[i]);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [7:0] rand_data();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'h7F;
      default: return 8'($urandom_range(0, 127));
    endcase
  endfunction

  // one random phrase: mostly well-formed, some broken, some noise
  task automatic build_phrase(ref logic [7:0] phrase[$]);
    int         pick;
    int         reps;
    int         n_data;
    logic [7:0] st;
    phrase.delete();
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      // channel message with a run of running status
      st     = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
      n_data = (st >= ST_PROG_LOW && st < ST_BEND_LOW) ? 1 : 2;
      reps   = $urandom_range(1, 4);
      phrase.push_back(st);
      for (int r = 0; r < reps; r++) begin
        for (int d = 0; d < n_data; d++) begin
          if ($urandom_range(0, 11) == 0) phrase.push_back(8'($urandom_range(8'hF8, 8'hFF)));
          phrase.push_back(rand_data());
        end
      end
    end else if (pick < 74) begin
      // system common, with a stray data byte now and then
      case ($urandom_range(0, 7))
        0: st = ST_MTC_QF;
        1: st = ST_SONG_POS;
        2: st = ST_SONG_SEL;
        3: st = ST_TUNE_REQ;
        default: st = 8'($urandom_range(ST_SYS_LOW, 8'hF7));
      endcase
      phrase.push_back(st);
      if (st == ST_SONG_POS) n_data = 2;
      else if (st == ST_MTC_QF || st == ST_SONG_SEL) n_data = 1;
      else n_data = $urandom_range(0, 2);
      for (int d = 0; d < n_data; d++) phrase.push_back(rand_data());
      if ($urandom_range(0, 3) == 0) phrase.push_back(rand_data());
    end else if (pick < 82) begin
      phrase.push_back(8'($urandom_range(8'hF8, 8'hFF)));
    end else if (pick < 92) begin
      // cut-off message: one data byte short, the next status drops it
      st = ($urandom_range(0, 3) == 0) ? ST_SONG_POS
                                       : {1'b1, 3'($urandom_range(0, 3)), 4'($urandom)};
      if (st >= ST_PROG_LOW && st < ST_BEND_LOW) st = {3'b111, 1'b0, st[3:0]};
      phrase.push_back(st);
      phrase.push_back(rand_data());
      phrase.push_back({1'b1, 3'($urandom_range(0, 6)), 4'($urandom)});
    end else begin
      reps = $urandom_range(1, 4);
      for (int i = 0; i < reps; i++) phrase.push_back(8'($urandom));
    end
  endtask

  // result side: check each beat, stall on a rotating mask, long hold on request
  int         hold_ack = 0;
  int         hold_left = 0;
  int         mask_age = 0;
  logic [7:0] pop_mask = 8'hFF;

  always @(posedge clk) begin
    beat_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (due_beats.size() == 0) begin
          $error("unexpected beat out_tx_byte %02h out_last_of_run %0b",
                 out_tx_byte, out_last_of_run);
          n_fail++;
        end else begin
          want = due_beats.pop_front();
          if (out_tx_byte !== want.tx) begin
            $error("out_tx_byte expected %02h actual %02h", want.tx, out_tx_byte);
            n_fail++;
          end
          if (out_last_of_run !== want.last) begin
            $error("out_last_of_run expected %0b actual %0b", want.last, out_last_of_run);
            n_fail++;
          end
        end
      end
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = LONG_HOLD;
      end
      if (mask_age == 0) begin
        mask_age = $urandom_range(16, 96);
        pop_mask = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
        if (pop_mask == 8'h00) pop_mask = 8'h01;
      end
      mask_age--;
      pop_mask = {pop_mask[0], pop_mask[7:1]};
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= pop_mask[0];
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [7:0] phrase[$];
    int         counted;
    logic       pressed;
    logic       paused;

    dir_rows = '{
      '{8'h00, 1'b1, 2'd0, 24'h000000},  // data with no running status
      '{8'hF8, 1'b1, 2'd1, 24'hF80000},  // lowest real-time byte
      '{8'hF6, 1'b1, 2'd1, 24'hF60000},  // tune request
      '{8'h90, 1'b0, 2'd0, 24'h000000},
      '{8'h3C, 1'b0, 2'd0, 24'h000000},
      '{8'hFE, 1'b1, 2'd1, 24'hFE0000},  // real-time inside a message
      '{8'h7F, 1'b0, 2'd0, 24'h000000},
      '{8'h00, 1'b0, 2'd0, 24'h000000},  // running status
      '{8'h40, 1'b0, 2'd0, 24'h000000},
      '{8'hC5, 1'b0, 2'd0, 24'h000000},
      '{8'h7F, 1'b0, 2'd0, 24'h000000},
      '{8'hE3, 1'b0, 2'd0, 24'h000000},
      '{8'h12, 1'b0, 2'd0, 24'h000000},
      '{8'hB0, 1'b0, 2'd0, 24'h000000},  // cuts off the pitch bend
      '{8'h07, 1'b0, 2'd0, 24'h000000},
      '{8'h64, 1'b0, 2'd0, 24'h000000},
      '{8'hF2, 1'b0, 2'd0, 24'h000000},
      '{8'h01, 1'b0, 2'd0, 24'h000000},
      '{8'h02, 1'b0, 2'd0, 24'h000000},
      '{8'h05, 1'b1, 2'd0, 24'h000000},  // running status cleared by song position
      '{8'hF1, 1'b0, 2'd0, 24'h000000},
      '{8'h33, 1'b0, 2'd0, 24'h000000},
      '{8'hF0, 1'b0, 2'd0, 24'h000000},
      '{8'h11, 1'b1, 2'd0, 24'h000000},  // data under an unsupported system status
      '{8'hFF, 1'b1, 2'd1, 24'hFF0000}   // highest real-time byte
    };

    rs_last    = ST_NONE;
    rs_running = ST_NONE;
    rs_pending = 1'b0;
    rs_first   = 7'h00;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) begin
        push       <= 1'b1;
        in_rx_byte <= dir_rows[i].rx;
        @(posedge clk);
        while (full) @(posedge clk);
        reassemble_byte(dir_rows[i].rx);
        for (int k = 0; k < int'(dir_rows[i].n); k++)
          due_beats.push_back('{tx: dir_rows[i].bytes[23 - 8 * k -: 8],
                                last: (k == int'(dir_rows[i].n) - 1)});
      end else begin
        send_byte(dir_rows[i].rx);
      end
    end

    // random phrases, with one long result stall and one full drain on the way
    counted = 0;
    pressed = 1'b0;
    paused  = 1'b0;
    while (counted < RANDOM_ITEMS) begin
      if (!pressed && counted >= RANDOM_ITEMS / 3) begin
        pressed  = 1'b1;
        hold_req <= hold_req + 1;
        burst_left = 60;
      end
      if (!paused && counted >= 2 * RANDOM_ITEMS / 3) begin
        paused = 1'b1;
        push <= 1'b0;
        wait (due_beats.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
      end
      build_phrase(phrase);
      foreach (phrase[i]) begin
        send_byte(phrase[i]);
        if (!byte_ignored) counted++;
      end
    end
    push <= 1'b0;

    wait (due_beats.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (due_beats.size() != 0) begin
      $error("%0d beats never arrived", due_beats.size());
      n_fail++;
    end

    if (n_fail == 0) begin
      $display("midi_running_status_reassembler_unit verification clean");
    end else begin
      $display("midi_running_status_reassembler_unit verification failed");
    end
    $finish;
  end

endmodule
